// ===== rtl/bfs_pkg.sv =====
// bfs_pkg: shared constants for the bilinear fit scaler
// no dependencies; imported by bilinear_fit_scaler and tb_bilinear_fit_scaler
package bfs_pkg;

	// default frame and source store sizes
	localparam int DEST_WIDTH_DEF     = 512;
	localparam int DEST_HEIGHT_DEF    = 512;
	localparam int SRC_MAX_PIXELS_DEF = 262144;

	// fixed field widths
	localparam int SIZE_W  = 10;
	localparam int COLOR_W = 24;
	localparam int XR_W    = 18;
	localparam int ACC_W   = 16;
	localparam int FA_W    = 20;

	// item kinds carried in the input tuser
	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_REQUEST = 1'b1;

	// configuration register indexes
	localparam logic CFG_SRC_WIDTH  = 1'b0;
	localparam logic CFG_SRC_HEIGHT = 1'b1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd512;

endpackage

// ===== rtl/bfs_div.sv =====
// bfs_div: restoring divider, one quotient bit per cycle
// no dependencies; shared by the fit and ratio steps of bilinear_fit_scaler
module bfs_div #(
	parameter int N_W = 20,
	parameter int D_W = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           busy,
	output logic           done,
	output logic [N_W-1:0] quo
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [D_W:0] trial;
	logic [D_W:0] diff;
	logic         fits;

	// one trial subtraction per cycle
	assign trial = {rem_q, quo_q[N_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
			quo_q <= {quo_q[N_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/bfs_mem.sv =====
// bfs_mem: source pixel store, one write and one registered read port
// no dependencies; instantiated by bilinear_fit_scaler
module bfs_mem #(
	parameter int DEPTH  = 262144,
	parameter int ADDR_W = 18,
	parameter int DATA_W = 24
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/bilinear_fit_scaler.sv =====
// bilinear_fit_scaler: load items are written in the idle state; a request inside
// the image runs three divisions on the shared bit-serial divider, one outside only
// the fit division; the single multiplier forms coordinates, row offsets, weights
// and twelve channel products
// reset clears control and sets both size registers to 512; the store is not cleared
// depends on bfs_pkg, bfs_div, bfs_mem
module bilinear_fit_scaler
	import bfs_pkg::*;
#(
	parameter int DEST_WIDTH     = DEST_WIDTH_DEF,
	parameter int DEST_HEIGHT    = DEST_HEIGHT_DEF,
	parameter int SRC_MAX_PIXELS = SRC_MAX_PIXELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [SIZE_W-1:0] cfg_data,
	// input items
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [63:0]       s_axis_tdata,  // pixel_index, pixel_value, dest_x, dest_y
	input  logic              s_axis_tuser,  // mode
	// result items
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [55:0]       m_axis_tdata,  // pixel_out, rotate_right, fit_width, fit_height
	output logic              m_axis_tuser   // inside_image
);

	localparam int DMAX   = (DEST_WIDTH > DEST_HEIGHT) ? DEST_WIDTH : DEST_HEIGHT;
	localparam int DIMW   = $clog2(DMAX + 1);
	localparam int DIV_W  = (SIZE_W + DIMW > XR_W) ? SIZE_W + DIMW : XR_W;
	localparam int DEN_W  = (DIMW > SIZE_W) ? DIMW : SIZE_W;
	localparam int MB_W   = (DIMW > SIZE_W) ? DIMW : SIZE_W;
	localparam int PROD_W = XR_W + MB_W;
	localparam int CMP_W  = ((DIMW > 9) ? DIMW : 9) + 1;
	localparam int ADDR_W = (SRC_MAX_PIXELS > 1) ? $clog2(SRC_MAX_PIXELS) : 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FIT  = 4'd1;
	localparam logic [3:0] S_FITW = 4'd2;
	localparam logic [3:0] S_XS   = 4'd3;
	localparam logic [3:0] S_XRW  = 4'd4;
	localparam logic [3:0] S_YRW  = 4'd5;
	localparam logic [3:0] S_MX   = 4'd6;
	localparam logic [3:0] S_MY   = 4'd7;
	localparam logic [3:0] S_ROW0 = 4'd8;
	localparam logic [3:0] S_ROW1 = 4'd9;
	localparam logic [3:0] S_WT   = 4'd10;
	localparam logic [3:0] S_RD   = 4'd11;
	localparam logic [3:0] S_MAC  = 4'd12;
	localparam logic [3:0] S_OUT  = 4'd13;

	logic [3:0] state_q;

	logic [SIZE_W-1:0] src_width_q;
	logic [SIZE_W-1:0] src_height_q;

	logic [8:0]        dx_q;
	logic [8:0]        dy_q;
	logic [DIMW-1:0]   fw_q;
	logic [DIMW-1:0]   fh_q;
	logic [DIMW-1:0]   j_q;
	logic [DIMW-1:0]   i_q;
	logic              inside_q;
	logic [XR_W-1:0]   xr_q;
	logic [XR_W-1:0]   yr_q;
	logic [PROD_W-1:0] xdf_q;
	logic [PROD_W-1:0] ydf_q;
	logic [FA_W-1:0]   rowa_q;
	logic [FA_W-1:0]   rowc_q;
	logic [8:0]        wt_q [4];
	logic [ACC_W-1:0]  acc_q [3];
	logic [1:0]        idx_q;
	logic [1:0]        ch_q;
	logic              rd_ok_q;

	logic              out_valid_q;
	logic [31:0]       out_pix_q;
	logic              out_inside_q;
	logic              out_rot_q;
	logic [SIZE_W-1:0] out_fw_q;
	logic [SIZE_W-1:0] out_fh_q;

	// input fields
	logic              in_mode;
	logic [17:0]       in_index;
	logic [COLOR_W-1:0] in_value;
	assign in_mode  = s_axis_tuser;
	assign in_index = s_axis_tdata[17:0];
	assign in_value = s_axis_tdata[41:18];

	logic in_accept;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// effective sizes, zero reads as one
	logic [SIZE_W-1:0] w;
	logic [SIZE_W-1:0] h;
	logic              rot;
	assign w   = (src_width_q == '0) ? SIZE_W'(1) : src_width_q;
	assign h   = (src_height_q == '0) ? SIZE_W'(1) : src_height_q;
	assign rot = !(w < h);

	// divider
	logic             div_start;
	logic [DIV_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic             div_busy;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;

	bfs_div #(
		.N_W (DIV_W),
		.D_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// fitted size clamp
	logic [DIV_W-1:0] fit_limit;
	logic [DIMW-1:0]  fit_clamped;
	assign fit_limit   = rot ? DIV_W'(DEST_HEIGHT) : DIV_W'(DEST_WIDTH);
	assign fit_clamped = (div_quo == '0) ? DIMW'(1) :
		(div_quo > fit_limit) ? DIMW'(fit_limit) : DIMW'(div_quo);

	// centering offsets and inside test
	logic [DIMW-1:0]  xs;
	logic [DIMW-1:0]  ys;
	logic [CMP_W-1:0] dxc;
	logic [CMP_W-1:0] dyc;
	logic             in_image;
	assign xs       = DIMW'((DIMW'(DEST_WIDTH) - fw_q) >> 1);
	assign ys       = DIMW'((DIMW'(DEST_HEIGHT) - fh_q) >> 1);
	assign dxc      = CMP_W'(dx_q);
	assign dyc      = CMP_W'(dy_q);
	assign in_image = (dxc >= CMP_W'(xs)) && (dxc < CMP_W'(xs) + CMP_W'(fw_q)) &&
		(dyc >= CMP_W'(ys)) && (dyc < CMP_W'(ys) + CMP_W'(fh_q));

	// source coordinates and clamped neighbours
	logic [SIZE_W-1:0] x;
	logic [SIZE_W-1:0] y;
	logic [SIZE_W-1:0] x1;
	logic [SIZE_W-1:0] y1;
	logic [7:0]        xd;
	logic [7:0]        yd;
	logic [8:0]        ixd;
	logic [8:0]        iyd;
	assign x   = xdf_q[17:8];
	assign y   = ydf_q[17:8];
	assign xd  = xdf_q[7:0];
	assign yd  = ydf_q[7:0];
	assign x1  = ({1'b0, x} + 11'd1 < {1'b0, w}) ? x + 1'b1 : w - 1'b1;
	assign y1  = ({1'b0, y} + 11'd1 < {1'b0, h}) ? y + 1'b1 : h - 1'b1;
	assign ixd = 9'd256 - {1'b0, xd};
	assign iyd = 9'd256 - {1'b0, yd};

	// neighbour address
	logic [FA_W-1:0] rd_addr;
	always_comb begin
		case (idx_q)
			2'd0:    rd_addr = rowa_q + FA_W'(x);
			2'd1:    rd_addr = rowa_q + FA_W'(x1);
			2'd2:    rd_addr = rowc_q + FA_W'(x);
			default: rd_addr = rowc_q + FA_W'(x1);
		endcase
	end

	// source store
	logic               mem_we;
	logic               mem_re;
	logic [COLOR_W-1:0] mem_rdata;
	assign mem_we = in_accept && (in_mode == MODE_LOAD) &&
		(32'(in_index) < 32'(SRC_MAX_PIXELS));
	assign mem_re = (state_q == S_RD);

	bfs_mem #(
		.DEPTH  (SRC_MAX_PIXELS),
		.ADDR_W (ADDR_W),
		.DATA_W (COLOR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (ADDR_W'(in_index)),
		.wdata (in_value),
		.re    (mem_re),
		.raddr (ADDR_W'(rd_addr)),
		.rdata (mem_rdata)
	);

	// neighbour channel, zero beyond the store
	logic [COLOR_W-1:0] nb_pix;
	logic [7:0]         chan;
	assign nb_pix = rd_ok_q ? mem_rdata : '0;
	always_comb begin
		case (ch_q)
			2'd0:    chan = nb_pix[23:16];
			2'd1:    chan = nb_pix[15:8];
			default: chan = nb_pix[7:0];
		endcase
	end

	// shared multiplier operand select
	logic [XR_W-1:0]   mul_a;
	logic [MB_W-1:0]   mul_b;
	logic [PROD_W-1:0] mul_p;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MX: begin
				mul_a = xr_q;
				mul_b = MB_W'(j_q);
			end
			S_MY: begin
				mul_a = yr_q;
				mul_b = MB_W'(i_q);
			end
			S_ROW0: begin
				mul_a = XR_W'(y);
				mul_b = MB_W'(w);
			end
			S_ROW1: begin
				mul_a = XR_W'(y1);
				mul_b = MB_W'(w);
			end
			S_WT: begin
				case (idx_q)
					2'd0: begin
						mul_a = XR_W'(ixd);
						mul_b = MB_W'(iyd);
					end
					2'd1: begin
						mul_a = XR_W'(xd);
						mul_b = MB_W'(iyd);
					end
					2'd2: begin
						mul_a = XR_W'(yd);
						mul_b = MB_W'(ixd);
					end
					default: begin
						mul_a = XR_W'(xd);
						mul_b = MB_W'(yd);
					end
				endcase
			end
			S_MAC: begin
				mul_a = XR_W'(chan);
				mul_b = MB_W'(wt_q[idx_q]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			S_FIT: begin
				div_start = 1'b1;
				div_num   = rot ? DIV_W'(h) * DIV_W'(DEST_WIDTH) :
					DIV_W'(w) * DIV_W'(DEST_HEIGHT);
				div_den   = rot ? DEN_W'(w) : DEN_W'(h);
			end
			S_XS: begin
				div_start = in_image;
				div_num   = DIV_W'({w - 1'b1, 8'h00});
				div_den   = DEN_W'(fw_q);
			end
			S_XRW: begin
				div_start = div_done;
				div_num   = DIV_W'({h - 1'b1, 8'h00});
				div_den   = DEN_W'(fh_q);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SIZE_RESET;
			src_height_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_SRC_WIDTH) begin
				src_width_q <= cfg_data;
			end else begin
				src_height_q <= cfg_data;
			end
		end
	end

	// sequencer
	logic out_free;
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			ch_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_accept && (in_mode == MODE_REQUEST)) begin
						state_q <= S_FIT;
					end
				end
				S_FIT: state_q <= S_FITW;
				S_FITW: begin
					if (div_done) begin
						state_q <= S_XS;
					end
				end
				S_XS: state_q <= in_image ? S_XRW : S_OUT;
				S_XRW: begin
					if (div_done) begin
						state_q <= S_YRW;
					end
				end
				S_YRW: begin
					if (div_done) begin
						state_q <= S_MX;
					end
				end
				S_MX:   state_q <= S_MY;
				S_MY:   state_q <= S_ROW0;
				S_ROW0: state_q <= S_ROW1;
				S_ROW1: begin
					state_q <= S_WT;
					idx_q   <= '0;
				end
				S_WT: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == 2'd3) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_MAC;
					ch_q    <= '0;
				end
				S_MAC: begin
					if (ch_q == 2'd2) begin
						ch_q <= '0;
						if (idx_q == 2'd3) begin
							state_q <= S_OUT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_RD;
						end
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			dx_q <= s_axis_tdata[50:42];
			dy_q <= s_axis_tdata[59:51];
		end
		if (state_q == S_FITW && div_done) begin
			fw_q <= rot ? DIMW'(DEST_WIDTH) : fit_clamped;
			fh_q <= rot ? fit_clamped : DIMW'(DEST_HEIGHT);
		end
		if (state_q == S_XS) begin
			inside_q <= in_image;
			j_q      <= DIMW'(dxc - CMP_W'(xs));
			i_q      <= DIMW'(dyc - CMP_W'(ys));
		end
		if (state_q == S_XRW && div_done) begin
			xr_q <= XR_W'(div_quo);
		end
		if (state_q == S_YRW && div_done) begin
			yr_q <= XR_W'(div_quo);
		end
		if (state_q == S_MX) begin
			xdf_q <= mul_p;
		end
		if (state_q == S_MY) begin
			ydf_q <= mul_p;
		end
		if (state_q == S_ROW0) begin
			rowa_q <= FA_W'(mul_p);
		end
		if (state_q == S_ROW1) begin
			rowc_q <= FA_W'(mul_p);
		end
		if (state_q == S_WT) begin
			wt_q[idx_q] <= mul_p[16:8];
			if (idx_q == 2'd3) begin
				acc_q[0] <= '0;
				acc_q[1] <= '0;
				acc_q[2] <= '0;
			end
		end
		if (state_q == S_RD) begin
			rd_ok_q <= 32'(rd_addr) < 32'(SRC_MAX_PIXELS);
		end
		if (state_q == S_MAC) begin
			acc_q[ch_q] <= acc_q[ch_q] + ACC_W'(mul_p);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_pix_q    <= inside_q ?
				{8'h00, acc_q[2][15:8], acc_q[1][15:8], acc_q[0][15:8]} : 32'hFFFF_FFFF;
			out_inside_q <= inside_q;
			out_rot_q    <= rot;
			out_fw_q     <= rot ? SIZE_W'(fh_q) : SIZE_W'(fw_q);
			out_fh_q     <= rot ? SIZE_W'(fw_q) : SIZE_W'(fh_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_inside_q;
	assign m_axis_tdata  = {3'b000, out_fh_q, out_fw_q, out_rot_q, out_pix_q};

`ifndef SYNTHESIS
	// divider is never left running while the block is idle
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !div_busy)
		else $error("divider busy while idle");

	// a divider result only arrives in a state that waits for it
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_FITW || state_q == S_XRW || state_q == S_YRW))
		else $error("divider result outside a wait state");

	// an accepted request starts the sequence
	a_req_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && in_mode == MODE_REQUEST) |=> (state_q == S_FIT))
		else $error("request item did not start the sequence");

	// a new result is only loaded from the output state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("result appeared outside the output state");
`endif

endmodule

// ===== dv/tb_bilinear_fit_scaler.sv =====
// tb_bilinear_fit_scaler: self-checking testbench for the bilinear fit scaler
// drives size writes, load and request items, predicts or types in each scaled pixel and compares in order
// depends on bfs_pkg and bilinear_fit_scaler
`timescale 1ns / 100ps

module tb_bilinear_fit_scaler;
	import bfs_pkg::*;

	localparam int DW = DEST_WIDTH_DEF;
	localparam int DH = DEST_HEIGHT_DEF;
	localparam int STORE_DEPTH = SRC_MAX_PIXELS_DEF;
	localparam int DRAIN_CYCLES = 400;
	localparam int HOLD_CYCLES = 400;
	localparam longint CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [31:0]       pix;
		logic              in_img;
		logic              rot;
		logic [SIZE_W-1:0] fw;
		logic [SIZE_W-1:0] fh;
	} scaled_px_t;

	typedef enum {ROW_CFG, ROW_LOAD, ROW_REQ} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		int         a;     // width, store index or dest_x
		int         b;     // height, colour or dest_y
		bit         typed;
		scaled_px_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = CFG_SRC_WIDTH;
	logic [SIZE_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic s_axis_tuser = MODE_LOAD;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic m_axis_tuser;

	bilinear_fit_scaler dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [23:0] src_img [0:STORE_DEPTH-1];
	bit written [0:STORE_DEPTH-1];
	int unsigned cur_w = 512;
	int unsigned cur_h = 512;
	scaled_px_t pending_px [$];
	int fails = 0;
	bit quiet = 1'b0;
	int hold_req = 0;
	longint cycles = 0;

	// fitted geometry and the four neighbour addresses of one destination pixel
	function automatic void locate(input int unsigned dx, input int unsigned dy,
		output bit ins, output bit rot, output longint unsigned fw,
		output longint unsigned fh, output longint unsigned ad[4],
		output longint unsigned xd, output longint unsigned yd);
		longint unsigned w, h, xs, ys, xr, yr, x, y, x1, y1;
		w = (cur_w == 0) ? 1 : cur_w;
		h = (cur_h == 0) ? 1 : cur_h;
		fw = DW;
		fh = DH;
		rot = !(w < h);
		if (!rot) begin
			fw = (w * DH) / h;
			if (fw < 1) fw = 1;
			if (fw > DW) fw = DW;
		end else begin
			fh = (h * DW) / w;
			if (fh < 1) fh = 1;
			if (fh > DH) fh = DH;
		end
		xs = (DW - fw) >> 1;
		ys = (DH - fh) >> 1;
		ins = dx >= xs && dx < xs + fw && dy >= ys && dy < ys + fh;
		xr = ((w - 1) << 8) / fw;
		yr = ((h - 1) << 8) / fh;
		yd = yr * (dy - ys);
		xd = xr * (dx - xs);
		y = yd >> 8;
		x = xd >> 8;
		yd &= 'hFF;
		xd &= 'hFF;
		x1 = (x + 1 < w) ? x + 1 : w - 1;
		y1 = (y + 1 < h) ? y + 1 : h - 1;
		ad[0] = y * w + x;
		ad[1] = y * w + x1;
		ad[2] = y1 * w + x;
		ad[3] = y1 * w + x1;
	endfunction

	function automatic longint unsigned src_at(longint unsigned addr);
		if (addr >= STORE_DEPTH) return 0;
		return src_img[addr];
	endfunction

	// expected output word for a request item
	function automatic scaled_px_t scale_pixel(int unsigned dx, int unsigned dy);
		scaled_px_t r;
		bit ins, rot;
		longint unsigned fw, fh, xd, yd, ixd, iyd, m, n, o, p;
		longint unsigned a, b, c, d, red, grn, blu;
		longint unsigned ad[4];
		locate(dx, dy, ins, rot, fw, fh, ad, xd, yd);
		r.pix = 32'hFFFF_FFFF;
		if (ins) begin
			a = src_at(ad[0]);
			b = src_at(ad[1]);
			c = src_at(ad[2]);
			d = src_at(ad[3]);
			ixd = 256 - xd;
			iyd = 256 - yd;
			m = (ixd * iyd) >> 8;
			n = (xd * iyd) >> 8;
			o = (yd * ixd) >> 8;
			p = (xd * yd) >> 8;
			red = (((a & 'hff0000) * m + (b & 'hff0000) * n + (c & 'hff0000) * o
				+ (d & 'hff0000) * p) & 'hFFFFFFFF) >> 24;
			grn = (((a & 'hff00) * m + (b & 'hff00) * n + (c & 'hff00) * o
				+ (d & 'hff00) * p) & 'hFFFFFFFF) >> 16;
			blu = (((a & 'hff) * m + (b & 'hff) * n + (c & 'hff) * o
				+ (d & 'hff) * p) & 'hFFFFFFFF) >> 8;
			r.pix = 32'(((blu << 16) & 'hff0000) | ((grn << 8) & 'hff00) | (red & 'hff));
		end
		r.in_img = ins;
		r.rot = rot;
		r.fw = SIZE_W'(rot ? fh : fw);
		r.fh = SIZE_W'(rot ? fw : fh);
		return r;
	endfunction

	// one input item, with an optional random gap before it
	task automatic send_item(logic mode, int unsigned idx, int unsigned val,
		int unsigned dx, int unsigned dy);
		if (!quiet && $urandom_range(99) < 28) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= {4'b0, dy[8:0], dx[8:0], val[23:0], idx[17:0]};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic load_pixel(int unsigned idx, int unsigned val);
		send_item(MODE_LOAD, idx, val, $urandom_range(511), $urandom_range(511));
		if (idx < STORE_DEPTH) begin
			src_img[idx] = val[23:0];
			written[idx] = 1'b1;
		end
	endtask

	// fill any unwritten neighbour first, then ask for the pixel
	task automatic request_pixel(int unsigned dx, int unsigned dy, bit typed,
		scaled_px_t want);
		bit ins, rot;
		longint unsigned fw, fh, xd, yd;
		longint unsigned ad[4];
		locate(dx, dy, ins, rot, fw, fh, ad, xd, yd);
		if (ins) begin
			for (int k = 0; k < 4; k++) begin
				if (ad[k] < STORE_DEPTH && !written[ad[k]])
					load_pixel(32'(ad[k]), $urandom_range(24'hFFFFFF));
			end
		end
		send_item(MODE_REQUEST, $urandom_range(18'h3FFFF), $urandom_range(24'hFFFFFF),
			dx, dy);
		pending_px.push_back(typed ? want : scale_pixel(dx, dy));
	endtask

	// valid stays high across back-to-back writes; the caller drops it
	task automatic write_reg(logic idx, int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[SIZE_W-1:0];
		do @(posedge clk); while (!cfg_ready);
	endtask

	// sizes change only once the block has drained
	task automatic set_size(int unsigned w, int unsigned h);
		s_axis_tvalid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(CFG_SRC_WIDTH, w);
		write_reg(CFG_SRC_HEIGHT, h);
		cfg_valid <= 1'b0;
		cur_w = w;
		cur_h = h;
	endtask

	function automatic int unsigned pick_size();
		int unsigned r;
		r = $urandom_range(9);
		if (r < 6) return $urandom_range(1, 16);
		if (r == 6) return 1;
		if (r == 7) return 512;
		return $urandom_range(1, 512);
	endfunction

	// result checker and receiver stalls
	int hold_seen = 0;
	int hold_cnt = 0;
	always @(posedge clk) begin
		scaled_px_t want, got;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[32],
				m_axis_tdata[42:33], m_axis_tdata[52:43]};
			if (pending_px.size() == 0) begin
				$error("result item with nothing expected: %h", m_axis_tdata);
				fails++;
			end else begin
				want = pending_px.pop_front();
				if (got.pix !== want.pix) begin
					$error("pixel_out expected %h actual %h", want.pix, got.pix);
					fails++;
				end
				if (got.in_img !== want.in_img) begin
					$error("inside_image expected %b actual %b", want.in_img, got.in_img);
					fails++;
				end
				if (got.rot !== want.rot) begin
					$error("rotate_right expected %b actual %b", want.rot, got.rot);
					fails++;
				end
				if (got.fw !== want.fw) begin
					$error("fit_width expected %0d actual %0d", want.fw, got.fw);
					fails++;
				end
				if (got.fh !== want.fh) begin
					$error("fit_height expected %0d actual %0d", want.fh, got.fh);
					fails++;
				end
			end
		end
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cnt <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= quiet || ($urandom_range(99) >= 28);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// directed rows: some outside-image answers are typed in, the rest predicted
	stim_row_t rows [] = '{
		'{ROW_CFG,  1, 512, 0, '0},
		'{ROW_REQ,  0,   0, 1, '{32'hFFFFFFFF, 1'b0, 1'b0, 10'd1, 10'd512}},
		'{ROW_REQ, 511, 511, 1, '{32'hFFFFFFFF, 1'b0, 1'b0, 10'd1, 10'd512}},
		'{ROW_LOAD, 0, 24'hFFFFFF, 0, '0},
		'{ROW_LOAD, 262143, 24'h000000, 0, '0},
		'{ROW_LOAD, 1, 24'hFF00FF, 0, '0},
		'{ROW_REQ, 255,   0, 0, '0},
		'{ROW_REQ, 255, 511, 0, '0},
		'{ROW_REQ, 255, 300, 0, '0},
		'{ROW_CFG, 512,   1, 0, '0},
		'{ROW_REQ,  0,   0, 1, '{32'hFFFFFFFF, 1'b0, 1'b1, 10'd1, 10'd512}},
		'{ROW_REQ,  0, 255, 0, '0},
		'{ROW_REQ, 511, 255, 0, '0},
		'{ROW_CFG, 512, 512, 0, '0},
		'{ROW_REQ,  0,   0, 0, '0},
		'{ROW_REQ, 511, 511, 0, '0},
		'{ROW_REQ, 256, 256, 0, '0},
		'{ROW_CFG,  1,   1, 0, '0},
		'{ROW_REQ,  0,   0, 0, '0},
		'{ROW_REQ, 511, 511, 0, '0},
		'{ROW_CFG,  3,   7, 0, '0},
		'{ROW_REQ, 100, 200, 0, '0},
		'{ROW_REQ,  0, 300, 1, '{32'hFFFFFFFF, 1'b0, 1'b0, 10'd219, 10'd512}}
	};

	// stimulus
	initial begin
		int unsigned w, h, r;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			case (rows[i].kind)
				ROW_CFG: set_size(rows[i].a, rows[i].b);
				ROW_LOAD: load_pixel(rows[i].a, rows[i].b);
				default: request_pixel(rows[i].a, rows[i].b, rows[i].typed, rows[i].want);
			endcase
		end

		// random phases, each under its own sizes
		for (int ph = 0; ph < 8; ph++) begin
			w = pick_size();
			h = pick_size();
			set_size(w, h);
			quiet = (ph == 2);
			for (int n = 0; n < 100; n++) begin
				if (ph == 4 && n == 10) hold_req++;
				r = $urandom_range(99);
				if (r < 60) begin
					request_pixel($urandom_range(511), $urandom_range(511), 1'b0, '0);
				end else if (r < 75) begin
					load_pixel($urandom_range(w * h - 1), $urandom_range(24'hFFFFFF));
				end else begin
					load_pixel($urandom_range(18'h3FFFF), $urandom_range(24'hFFFFFF));
				end
			end
			quiet = 1'b0;
		end

		s_axis_tvalid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
